// ===== rtl/handle_pool_swap_remove_macros.svh =====
// ----------------------------------------------------------------------------
// handle pool assertion macros
// shared property forms for the handle pool checker
// ----------------------------------------------------------------------------
`ifndef HANDLE_POOL_SWAP_REMOVE_MACROS_SVH
`define HANDLE_POOL_SWAP_REMOVE_MACROS_SVH

// same-cycle implication
`define HPSR_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HPSR_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpsr_pkg.sv =====
// ----------------------------------------------------------------------------
// hpsr_pkg
// shared widths, operation and status codes, and control structs
// ----------------------------------------------------------------------------
`default_nettype none

package hpsr_pkg;

    localparam int POOL_SLOTS_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    localparam int FUNC_W   = 3;
    localparam int HANDLE_W = 4;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE_H  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE_IX = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTORE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESET     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FIND      = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_ITERATE   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // table read address select
    localparam logic [1:0] RD_ACTIVE = 2'd0;
    localparam logic [1:0] RD_PTR    = 2'd1;
    localparam logic [1:0] RD_OTHER  = 2'd2;
    localparam logic [1:0] RD_SIDX   = 2'd3;

    typedef struct packed {
        logic       latch;
        logic       init;
        logic       scan_en;
        logic [1:0] rd_sel;
        logic       cap_tmp;
        logic       wr_first;
        logic       wr_second;
        logic       finish;
        logic       iter_emit;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ridx_ok;
        logic              iter_empty;
        logic              scan_done;
        logic              found;
        logic              iter_last;
        logic              out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/hpsr_datapath.sv =====
// ----------------------------------------------------------------------------
// hpsr_datapath
// handle table, counts, scan pointer and the result word register
// ----------------------------------------------------------------------------
`default_nettype none

module hpsr_datapath #(
    parameter int POOL_SLOTS = hpsr_pkg::POOL_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire hpsr_pkg::cmd_t                cmd,
    output hpsr_pkg::stat_t                    stat,
    input  wire logic [hpsr_pkg::FUNC_W-1:0]   s_func,
    input  wire logic [hpsr_pkg::HANDLE_W-1:0] s_handle,
    input  wire logic [hpsr_pkg::INDEX_W-1:0]  s_slot_index,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic [hpsr_pkg::STATUS_W-1:0]      m_status,
    output logic [hpsr_pkg::HANDLE_W-1:0]      m_out_handle,
    output logic [hpsr_pkg::INDEX_W-1:0]       m_out_index,
    output logic [hpsr_pkg::ACTIVE_W-1:0]      m_active_now,
    output logic                               m_last
);
    import hpsr_pkg::*;

    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    logic [HANDLE_W-1:0] handle_mem [POOL_SLOTS];

    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [INDEX_W-1:0]  sidx_reg, sidx_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    pool_reg, pool_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    found_idx_reg, found_idx_next;
    logic [HANDLE_W-1:0] tmp_reg, tmp_next;
    logic [HANDLE_W-1:0] rd_data_reg;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [ACTIVE_W-1:0] active_now_reg, active_now_next;
    logic                last_reg, last_next;

    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    other_idx;
    logic [CNT_W-1:0]    scan_to;
    logic                scan_hit;
    logic                issue;
    logic [CMP_W-1:0]    iter_n;
    logic                iter_last;
    logic                has_cached;
    logic                pool_full;
    logic                ridx_ok;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [HANDLE_W-1:0] wr_data;

    assign other_idx  = (func_reg == FUNC_RESTORE) ? IDX_W'(active_reg)
                                                   : IDX_W'(active_reg - CNT_W'(1));
    assign scan_to    = (func_reg == FUNC_RESTORE) ? pool_reg : active_reg;
    assign scan_hit   = pend_reg && (rd_data_reg == handle_reg);
    assign issue      = cmd.scan_en && (ptr_reg < scan_to) && !scan_hit;
    assign iter_n     = (CMP_W'(active_reg) > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS)
                                                                   : CMP_W'(active_reg);
    assign iter_last  = ((CMP_W'(ptr_reg) + CMP_W'(1)) == iter_n);
    assign has_cached = (active_reg < pool_reg);
    assign pool_full  = (CMP_W'(pool_reg) >= CMP_W'(POOL_SLOTS));
    assign ridx_ok    = (CMP_W'(sidx_reg) < CMP_W'(active_reg));

    always_comb begin
        case (cmd.rd_sel)
            RD_PTR:   rd_addr = ptr_reg[IDX_W-1:0];
            RD_OTHER: rd_addr = other_idx;
            RD_SIDX:  rd_addr = IDX_W'(sidx_reg);
            default:  rd_addr = IDX_W'(active_reg);
        endcase
    end

    // table write port: swap halves and minting of a new handle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = found_idx_reg;
        wr_data = rd_data_reg;
        if (cmd.wr_first) begin
            wr_en = 1'b1;
        end else if (cmd.wr_second) begin
            wr_en   = 1'b1;
            wr_addr = other_idx;
            wr_data = tmp_reg;
        end else if (cmd.finish && (func_reg == FUNC_ALLOC) && !has_cached && !pool_full) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(pool_reg);
            wr_data = HANDLE_W'(pool_reg);
        end
    end

    always_comb begin
        func_next       = func_reg;
        handle_next     = handle_reg;
        sidx_next       = sidx_reg;
        active_next     = active_reg;
        pool_next       = pool_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        tmp_next        = tmp_reg;
        m_valid_next    = m_valid_reg;
        status_next     = status_reg;
        out_handle_next = out_handle_reg;
        out_index_next  = out_index_reg;
        active_now_next = active_now_reg;
        last_next       = last_reg;

        if (cmd.latch) begin
            func_next   = s_func;
            handle_next = s_handle;
            sidx_next   = s_slot_index;
        end

        if (cmd.init) begin
            ptr_next       = (func_reg == FUNC_RESTORE) ? active_reg : '0;
            pend_next      = 1'b0;
            found_next     = (func_reg == FUNC_REMOVE_IX) && ridx_ok;
            found_idx_next = IDX_W'(sidx_reg);
        end

        if (cmd.scan_en) begin
            pend_next = issue;
            if (issue) begin
                ptr_next      = ptr_reg + CNT_W'(1);
                pend_idx_next = ptr_reg[IDX_W-1:0];
            end
            if (scan_hit) begin
                found_next     = 1'b1;
                found_idx_next = pend_idx_reg;
                tmp_next       = rd_data_reg;
            end
        end

        if (cmd.cap_tmp) begin
            tmp_next = rd_data_reg;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.iter_emit) begin
            m_valid_next    = 1'b1;
            status_next     = ST_OK;
            out_handle_next = rd_data_reg;
            out_index_next  = INDEX_W'(ptr_reg);
            active_now_next = ACTIVE_W'(active_reg);
            last_next       = iter_last;
            ptr_next        = ptr_reg + CNT_W'(1);
        end

        if (cmd.finish) begin
            m_valid_next    = 1'b1;
            status_next     = ST_MISS;
            out_handle_next = '0;
            out_index_next  = '0;
            last_next       = 1'b1;
            case (func_reg)
                FUNC_ALLOC: begin
                    if (has_cached) begin
                        status_next     = ST_OK;
                        out_handle_next = rd_data_reg;
                        out_index_next  = INDEX_W'(active_reg);
                        active_next     = active_reg + CNT_W'(1);
                    end else if (pool_full) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next     = ST_OK;
                        out_handle_next = HANDLE_W'(pool_reg);
                        out_index_next  = INDEX_W'(pool_reg);
                        active_next     = active_reg + CNT_W'(1);
                        pool_next       = pool_reg + CNT_W'(1);
                    end
                end
                FUNC_REMOVE_H, FUNC_REMOVE_IX: begin
                    if (found_reg) begin
                        status_next     = ST_OK;
                        out_handle_next = tmp_reg;
                        out_index_next  = INDEX_W'(found_idx_reg);
                        active_next     = active_reg - CNT_W'(1);
                    end
                end
                FUNC_RESTORE: begin
                    if (found_reg) begin
                        status_next     = ST_OK;
                        out_handle_next = tmp_reg;
                        out_index_next  = INDEX_W'(active_reg);
                        active_next     = active_reg + CNT_W'(1);
                    end
                end
                FUNC_FIND: begin
                    if (found_reg) begin
                        status_next     = ST_OK;
                        out_handle_next = tmp_reg;
                        out_index_next  = INDEX_W'(found_idx_reg);
                    end
                end
                FUNC_RESET: begin
                    status_next = ST_OK;
                    active_next = '0;
                end
                default: begin
                    status_next = ST_MISS;
                end
            endcase
            active_now_next = ACTIVE_W'(active_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            pool_reg    <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            pool_reg    <= pool_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        handle_reg     <= handle_next;
        sidx_reg       <= sidx_next;
        pend_idx_reg   <= pend_idx_next;
        found_idx_reg  <= found_idx_next;
        tmp_reg        <= tmp_next;
        status_reg     <= status_next;
        out_handle_reg <= out_handle_next;
        out_index_reg  <= out_index_next;
        active_now_reg <= active_now_next;
        last_reg       <= last_next;
    end

    // handle table, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            handle_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= handle_mem[rd_addr];
    end

    assign stat.func       = func_reg;
    assign stat.ridx_ok    = ridx_ok;
    assign stat.iter_empty = (active_reg == '0);
    assign stat.scan_done  = scan_hit || (!pend_reg && (ptr_reg >= scan_to));
    assign stat.found      = found_reg || scan_hit;
    assign stat.iter_last  = iter_last;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_out_handle = out_handle_reg;
    assign m_out_index  = out_index_reg;
    assign m_active_now = active_now_reg;
    assign m_last       = last_reg;

endmodule

`default_nettype wire

// ===== rtl/hpsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpsr_ctrl
// sequencer for decode, table scan, swap and word emission
// ----------------------------------------------------------------------------
`default_nettype none

module hpsr_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output hpsr_pkg::cmd_t       cmd,
    input  wire hpsr_pkg::stat_t stat
);
    import hpsr_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_SWAP_RD  = 4'd3;
    localparam logic [3:0] S_SWAP_WR1 = 4'd4;
    localparam logic [3:0] S_SWAP_WR2 = 4'd5;
    localparam logic [3:0] S_RES      = 4'd6;
    localparam logic [3:0] S_ITER_RD  = 4'd7;
    localparam logic [3:0] S_ITER_OUT = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE) && aresetn;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ACTIVE;
        case (state_reg)
            S_IDLE: begin
                cmd.latch = s_valid && s_ready;
                if (s_valid && s_ready) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.init = 1'b1;
                if (stat.func == FUNC_REMOVE_IX) begin
                    cmd.rd_sel = RD_SIDX;
                end
                if (stat.func inside {FUNC_REMOVE_H, FUNC_FIND, FUNC_RESTORE}) begin
                    state_next = S_SCAN;
                end else if (stat.func == FUNC_REMOVE_IX) begin
                    state_next = stat.ridx_ok ? S_SWAP_RD : S_RES;
                end else if (stat.func == FUNC_ITERATE) begin
                    state_next = stat.iter_empty ? S_IDLE : S_ITER_RD;
                end else begin
                    state_next = S_RES;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                cmd.rd_sel  = RD_PTR;
                if (stat.scan_done) begin
                    if ((stat.func == FUNC_FIND) || !stat.found) begin
                        state_next = S_RES;
                    end else begin
                        state_next = S_SWAP_RD;
                    end
                end
            end
            S_SWAP_RD: begin
                cmd.rd_sel  = RD_OTHER;
                cmd.cap_tmp = (stat.func == FUNC_REMOVE_IX);
                state_next  = S_SWAP_WR1;
            end
            S_SWAP_WR1: begin
                cmd.wr_first = 1'b1;
                state_next   = S_SWAP_WR2;
            end
            S_SWAP_WR2: begin
                cmd.wr_second = 1'b1;
                state_next    = S_RES;
            end
            S_RES: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ITER_RD: begin
                cmd.rd_sel = RD_PTR;
                state_next = S_ITER_OUT;
            end
            S_ITER_OUT: begin
                cmd.rd_sel = RD_PTR;
                if (stat.out_free) begin
                    cmd.iter_emit = 1'b1;
                    state_next    = stat.iter_last ? S_IDLE : S_ITER_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/handle_pool_swap_remove.sv =====
// Alloc, reset, unused codes and an out-of-range index remove skip the scan and swap.
// Find, remove by handle and restore scan the table one entry a cycle until a hit or
// the end; a hit in remove or restore, or an in-range index remove, then swaps entries.
// Iterate emits a word per active entry, up to MAX_RESULTS, via the single read port.
// One operation at a time; the next is taken once the current word is registered.
// Reset: synchronous, clears both counts and the output valid; table contents are kept.
// ----------------------------------------------------------------------------
// handle_pool_swap_remove
// handle pool with swap-remove free list, controller plus datapath
// ----------------------------------------------------------------------------
`default_nettype none

module handle_pool_swap_remove #(
    parameter int POOL_SLOTS = hpsr_pkg::POOL_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [hpsr_pkg::FUNC_W-1:0]   s_func,
    input  wire logic [hpsr_pkg::HANDLE_W-1:0] s_handle,
    input  wire logic [hpsr_pkg::INDEX_W-1:0]  s_slot_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [hpsr_pkg::STATUS_W-1:0]      m_status,
    output logic [hpsr_pkg::HANDLE_W-1:0]      m_out_handle,
    output logic [hpsr_pkg::INDEX_W-1:0]       m_out_index,
    output logic [hpsr_pkg::ACTIVE_W-1:0]      m_active_now,
    output logic                               m_last
);
    import hpsr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    hpsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    hpsr_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_func       (s_func),
        .s_handle     (s_handle),
        .s_slot_index (s_slot_index),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_status     (m_status),
        .m_out_handle (m_out_handle),
        .m_out_index  (m_out_index),
        .m_active_now (m_active_now),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/hpsr_checker.sv =====
// ----------------------------------------------------------------------------
// hpsr_checker
// port-level checks on the handle pool, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "handle_pool_swap_remove_macros.svh"

module hpsr_checker #(
    parameter int POOL_SLOTS = hpsr_pkg::POOL_SLOTS_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [hpsr_pkg::STATUS_W-1:0] m_status,
    input wire logic [hpsr_pkg::HANDLE_W-1:0] m_out_handle,
    input wire logic [hpsr_pkg::INDEX_W-1:0]  m_out_index,
    input wire logic [hpsr_pkg::ACTIVE_W-1:0] m_active_now,
    input wire logic                          m_last
);
    import hpsr_pkg::*;

    `HPSR_ASSERT_NEXT(a_word_held, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_out_handle) && $stable(m_out_index) && $stable(m_active_now) && $stable(m_last), "stalled result word changed")
    `HPSR_ASSERT_NOW(a_fail_zero, aclk, !aresetn, m_valid && (m_status != ST_OK), (m_out_handle == '0) && (m_out_index == '0) && m_last, "failed operation word not cleared")
    `HPSR_ASSERT_NOW(a_full_count, aclk, !aresetn, m_valid && (m_status == ST_FULL), m_active_now == ACTIVE_W'(POOL_SLOTS), "pool full with active count short of the pool")
    `HPSR_ASSERT_NEXT(a_busy_after_accept, aclk, !aresetn, s_valid && s_ready && aresetn, !s_ready, "input taken again before the operation finished")
    `HPSR_ASSERT_NEXT(a_reset_clears, aclk, 1'b0, !aresetn, !m_valid, "result valid after reset")

endmodule

bind handle_pool_swap_remove hpsr_checker #(.POOL_SLOTS(POOL_SLOTS)) u_hpsr_checker (.*);

`default_nettype wire
